// ===== rtl/mrsa_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the memory range slot allocator.
// Depends on nothing; every other file of the block imports it.
package mrsa_pkg;

    localparam int SLOT_COUNT_DEF = 8;

    // Configuration register indexes.
    localparam logic CFG_RANGES_PRESENT = 1'b0;
    localparam logic CFG_ACTIVE_SLOTS   = 1'b1;

    // Request kinds.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_NO_SPACE = 2'd2;

    localparam logic [31:0] PAGE_HIGH_MASK = 32'hffff_f000;
    localparam logic [31:0] MASK_VALID_BIT = 32'h0000_0800;
    localparam logic [11:0] PAGE_LOW_MASK  = 12'hfff;

    typedef struct packed {
        logic        req_type;
        logic [63:0] range_base;
        logic [63:0] range_size;
        logic [7:0]  mem_type;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  slot;
        logic [31:0] base_word;
        logic [31:0] base_high_word;
        logic [31:0] mask_word;
        logic        invalidate_request;
    } t_result;

    // Request token that walks down the row of slot cells.
    typedef struct packed {
        logic        valid;
        logic        done;
        logic        req_type;
        logic [1:0]  status;
        logic [2:0]  slot;
        logic [31:0] key;
        logic [31:0] base_word;
        logic [31:0] base_high_word;
        logic [31:0] mask_word;
    } t_token;

endpackage

// ===== rtl/mrsa_cell.sv =====
`timescale 1ns / 1ps
// One descriptor slot of the allocator: holds its three words and passes the
// request token on to the next slot. Depends on mrsa_pkg.
module mrsa_cell
    import mrsa_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [3:0] i_active_slots,
    input  t_token     i_tok,
    output t_token     o_tok
);

    localparam logic [7:0] IdxVal = 8'(INDEX);

    logic [31:0] r_base_lo;
    logic [31:0] r_base_hi;
    logic [31:0] r_mask_lo;
    t_token      r_tok;
    t_token      n_tok;
    logic        w_in_range;
    logic        w_free;
    logic        w_match;
    logic        w_hit;

    assign w_in_range = IdxVal < {4'd0, i_active_slots};
    assign w_free     = (r_mask_lo & PAGE_HIGH_MASK) == 32'd0;
    assign w_match    = (r_base_lo & PAGE_HIGH_MASK) == i_tok.key;
    assign w_hit      = i_tok.valid && !i_tok.done && w_in_range &&
                        ((i_tok.req_type == REQ_FREE) ? (!w_free && w_match) : w_free);

    always_comb begin
        n_tok = i_tok;
        if (w_hit) begin
            n_tok.done   = 1'b1;
            n_tok.status = ST_OK;
            n_tok.slot   = 3'(INDEX);
            if (i_tok.req_type == REQ_FREE) begin
                n_tok.base_word      = 32'd0;
                n_tok.base_high_word = 32'd0;
                n_tok.mask_word      = 32'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_lo   <= 32'd0;
            r_base_hi   <= 32'd0;
            r_mask_lo   <= 32'd0;
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (w_hit) begin
                r_base_lo <= n_tok.base_word;
                r_base_hi <= n_tok.base_high_word;
                r_mask_lo <= n_tok.mask_word;
            end
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== rtl/mtrr_range_slot_allocator_unit.sv =====
`timescale 1ns / 1ps
// Memory range slot allocator: an accepted request's token passes through the slot cell
// registers in turn, and the result is registered after the last cell as one strobed beat.
// Busy is high for the token's whole walk through the row of slot cells and drops as
// the result is registered, so a request is only taken once the last one is through.
// Synchronous active-low reset clears every slot and restores the registers
// to ranges present and eight active slots. Results cannot be held off.
module mtrr_range_slot_allocator_unit
    import mrsa_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_cmd       i_cmd,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [3:0] i_cfg_wdata,
    output logic       o_result_valid,
    output t_result    o_result
);

    // Configuration registers. They are only written while the block is idle (the block
    // does not enforce it; the user is bound), so the cells may read them directly during a walk.
    logic       r_ranges_present;
    logic [3:0] r_active_slots;

    logic       r_busy;
    logic       r_out_valid;
    t_result    r_out;
    t_result    n_out;
    logic       w_accept;
    logic       w_bad;
    t_token     w_launch;
    t_token     w_tok [0:SLOT_COUNT];
    t_token     w_last;
    logic [31:0] w_size_pg;

    assign w_accept = start && !r_busy;

    // A request is refused before the walk when the feature is absent, the base is not page
    // aligned, or an allocation's size is not; the token then travels already finished.
    always_comb begin
        w_bad = !r_ranges_present || (i_cmd.range_base[11:0] & PAGE_LOW_MASK) != 12'd0;
        if (i_cmd.req_type == REQ_ALLOC &&
            (i_cmd.range_size[11:0] & PAGE_LOW_MASK) != 12'd0) begin
            w_bad = 1'b1;
        end
    end

    assign w_size_pg = i_cmd.range_size[31:0] & PAGE_HIGH_MASK;

    // The words an allocation would write are worked out once at launch.
    always_comb begin
        w_launch.valid          = w_accept;
        w_launch.done           = w_bad;
        w_launch.req_type       = i_cmd.req_type;
        w_launch.status         = w_bad ? ST_INVALID : ST_OK;
        w_launch.slot           = 3'd0;
        w_launch.key            = i_cmd.range_base[31:0];
        w_launch.base_word      = (i_cmd.range_base[31:0] & PAGE_HIGH_MASK) |
                                  {24'd0, i_cmd.mem_type};
        w_launch.base_high_word = i_cmd.range_base[63:32];
        w_launch.mask_word      = ~(w_size_pg - 32'd1) | MASK_VALID_BIT;
        if (w_bad) begin
            w_launch.base_word      = 32'd0;
            w_launch.base_high_word = 32'd0;
            w_launch.mask_word      = 32'd0;
        end
    end

    assign w_tok[0] = w_launch;

    // The row of slot cells: each one looks at the token, registers it for the next cell,
    // and claims it if its slot fits the request.
    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        mrsa_cell #(
            .INDEX(g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_active_slots(r_active_slots),
            .i_tok         (w_tok[g]),
            .o_tok         (w_tok[g+1])
        );
    end

    assign w_last = w_tok[SLOT_COUNT];

    // A token that no cell claimed becomes a failure: no free slot for an
    // allocation, not found for a free.
    always_comb begin
        n_out.status             = w_last.status;
        n_out.slot               = w_last.slot;
        n_out.base_word          = w_last.base_word;
        n_out.base_high_word     = w_last.base_high_word;
        n_out.mask_word          = w_last.mask_word;
        n_out.invalidate_request = w_last.done && (w_last.status == ST_OK);
        if (!w_last.done) begin
            n_out.status         = (w_last.req_type == REQ_FREE) ? ST_INVALID : ST_NO_SPACE;
            n_out.slot           = 3'd0;
            n_out.base_word      = 32'd0;
            n_out.base_high_word = 32'd0;
            n_out.mask_word      = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ranges_present <= 1'b1;
            r_active_slots   <= 4'd8;
            r_busy           <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_RANGES_PRESENT: r_ranges_present <= i_cfg_wdata[0];
                    CFG_ACTIVE_SLOTS:   r_active_slots   <= i_cfg_wdata;
                    default: ;
                endcase
            end
            r_out_valid <= w_last.valid;
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_last.valid) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_last.valid) begin
            r_out <= n_out;
        end
    end

    assign busy           = r_busy;
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule

// ===== dv/mtrr_range_slot_allocator_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the memory range slot allocator unit.
// Drives requests through the start/busy handshake, predicts each result beat from
// its own copy of the slot table and checks every strobed beat. Depends on mrsa_pkg.
module mtrr_range_slot_allocator_unit_tb;
    import mrsa_pkg::*;

    localparam int SLOT_COUNT = SLOT_COUNT_DEF;
    // Upper bound on the whole run, with ample headroom for every phase's requests.
    localparam int CYCLE_LIMIT = 500_000;
    localparam int TAIL_CYCLES = SLOT_COUNT + 1;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    t_cmd       cmd = '0;
    logic       cfg_we = 1'b0;
    logic       cfg_idx = CFG_RANGES_PRESENT;
    logic [3:0] cfg_wdata = 4'd0;
    logic       result_valid;
    t_result    result;

    mtrr_range_slot_allocator_unit #(
        .SLOT_COUNT(SLOT_COUNT)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (cmd),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_wdata   (cfg_wdata),
        .o_result_valid(result_valid),
        .o_result      (result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Our own copy of the descriptor table and of the two registers. They hold the
    // values that the unit holds once every accepted request has been processed.
    logic [31:0] mirror_base_low  [SLOT_COUNT] = '{default: '0};
    logic [31:0] mirror_base_high [SLOT_COUNT] = '{default: '0};
    logic [31:0] mirror_mask_low  [SLOT_COUNT] = '{default: '0};
    logic        cur_ranges_present = 1'b1;
    logic [3:0]  cur_active_slots = 4'd8;

    t_cmd        cmd_q[$];           // requests waiting to be driven
    t_result     slot_result_q[$];   // predicted result beats, oldest first
    logic [31:0] base_pool[$];       // low base words handed to allocates, for frees
    int unsigned sender_idle_pct = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    t_result     want;

    // Applies one request to the mirrored table and returns the beat it must cause.
    // A failed request leaves everything but the status at zero.
    function automatic t_result compute_slot_update(t_cmd c);
        t_result     r;
        int          lim;
        logic [31:0] sz;
        logic        hit;
        r = '0;
        r.status = ST_INVALID;
        hit = 1'b0;
        // Active counts above the table size only ever scan the whole table.
        lim = (int'(cur_active_slots) > SLOT_COUNT) ? SLOT_COUNT : int'(cur_active_slots);
        if (!cur_ranges_present) begin
            return r;
        end
        if (c.req_type == REQ_ALLOC) begin
            if (c.range_base[11:0] != 12'd0 || c.range_size[11:0] != 12'd0) begin
                return r;
            end
            r.status = ST_NO_SPACE;
            for (int i = 0; i < lim; i++) begin
                if (!hit && (mirror_mask_low[i] & PAGE_HIGH_MASK) == 32'd0) begin
                    hit = 1'b1;
                    sz = c.range_size[31:0] & PAGE_HIGH_MASK;
                    mirror_base_low[i]  = (c.range_base[31:0] & PAGE_HIGH_MASK)
                                          | {24'd0, c.mem_type};
                    mirror_base_high[i] = c.range_base[63:32];
                    // A size with zero low word yields just the valid bit, so the
                    // slot is written but still reads as free.
                    mirror_mask_low[i]  = ~(sz - 32'd1) | MASK_VALID_BIT;
                    r.status             = ST_OK;
                    r.slot               = i[2:0];
                    r.base_word          = mirror_base_low[i];
                    r.base_high_word     = mirror_base_high[i];
                    r.mask_word          = mirror_mask_low[i];
                    r.invalidate_request = 1'b1;
                end
            end
            if (!hit) begin
                r.status = ST_NO_SPACE;
            end
            return r;
        end
        if (c.range_base[11:0] != 12'd0) begin
            return r;
        end
        // Free matches on the low base word only; the high word is ignored.
        for (int i = 0; i < lim; i++) begin
            if (!hit && (mirror_mask_low[i] & PAGE_HIGH_MASK) != 32'd0
                    && (mirror_base_low[i] & PAGE_HIGH_MASK) == c.range_base[31:0]) begin
                hit = 1'b1;
                mirror_base_low[i]  = 32'd0;
                mirror_base_high[i] = 32'd0;
                mirror_mask_low[i]  = 32'd0;
                r.status             = ST_OK;
                r.slot               = i[2:0];
                r.invalidate_request = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
        if (mismatch_count < 100) begin
            $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, exp_val);
        end
        mismatch_count++;
    endtask

    // Driver: a request beat is taken at an edge where start is high and busy is
    // low. The prediction is made at that very edge, so the mirrored table moves
    // in the same order as the unit's own.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                slot_result_q.push_back(compute_slot_update(cmd));
            end
            if (!start || !busy) begin
                if (cmd_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    start <= 1'b1;
                    cmd <= cmd_q.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: each strobed beat lasts one cycle and cannot be held off, so it is
    // compared with the oldest prediction at the edge that ends that cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && result_valid) begin
            if (slot_result_q.size() == 0) begin
                report_mismatch("unexpected result beat", 64'(result), 64'd0);
            end else begin
                want = slot_result_q.pop_front();
                if (result.status !== want.status)
                    report_mismatch("status", 64'(result.status), 64'(want.status));
                if (result.slot !== want.slot)
                    report_mismatch("slot", 64'(result.slot), 64'(want.slot));
                if (result.base_word !== want.base_word)
                    report_mismatch("base_word", 64'(result.base_word),
                                    64'(want.base_word));
                if (result.base_high_word !== want.base_high_word)
                    report_mismatch("base_high_word", 64'(result.base_high_word),
                                    64'(want.base_high_word));
                if (result.mask_word !== want.mask_word)
                    report_mismatch("mask_word", 64'(result.mask_word),
                                    64'(want.mask_word));
                if (result.invalidate_request !== want.invalidate_request)
                    report_mismatch("invalidate_request", 64'(result.invalidate_request),
                                    64'(want.invalidate_request));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic push_cmd(logic req, logic [63:0] base, logic [63:0] size,
                            logic [7:0] mtype);
        t_cmd c;
        c.req_type   = req;
        c.range_base = base;
        c.range_size = size;
        c.mem_type   = mtype;
        cmd_q.push_back(c);
    endtask

    // Waits until every request has been accepted and answered and the unit is idle.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (cmd_q.size() != 0 || start || busy || slot_result_q.size() != 0);
    endtask

    task automatic write_config(logic idx, logic [3:0] value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_RANGES_PRESENT) begin
            cur_ranges_present = value[0];
        end else begin
            cur_active_slots = value;
        end
    endtask

    // Registers change only once the unit is quiet; the phase then sets its own pace.
    task automatic start_phase(logic present, logic [3:0] active, int unsigned idle);
        wait_drained();
        write_config(CFG_RANGES_PRESENT, {3'd0, present});
        write_config(CFG_ACTIVE_SLOTS, active);
        sender_idle_pct = idle;
        @(negedge i_clk);
    endtask

    // Table corner cases with the reset register values: fill, overflow, the two
    // alignment refusals, a size whose low word is zero, and free hits and misses.
    task automatic queue_directed();
        push_cmd(REQ_ALLOC, 64'h0, 64'h1000, 8'h00);
        push_cmd(REQ_ALLOC, 64'hffff_ffff_ffff_f000, 64'hffff_ffff_ffff_f000, 8'hff);
        push_cmd(REQ_ALLOC, 64'h0000_0001_0000_2000, 64'h1_0000_0000, 8'h06);
        push_cmd(REQ_ALLOC, 64'h1001, 64'h1000, 8'h01);
        push_cmd(REQ_ALLOC, 64'h2000, 64'h1800, 8'h01);
        push_cmd(REQ_FREE, 64'h3004, 64'h0, 8'h00);
        push_cmd(REQ_FREE, 64'h5000_0000, 64'h0, 8'h00);
        for (int k = 1; k <= 6; k++) begin
            push_cmd(REQ_ALLOC, 64'(k) << 16, 64'h1_0000, 8'h04);
        end
        push_cmd(REQ_ALLOC, 64'h7000_0000, 64'h1000, 8'h05);
        push_cmd(REQ_FREE, 64'h0000_0000_ffff_f000, 64'hffff_ffff_ffff_ffff, 8'hff);
        push_cmd(REQ_FREE, 64'hffff_ffff_0000_0000, 64'h0, 8'h00);
        push_cmd(REQ_FREE, 64'h0, 64'h0, 8'h00);
        push_cmd(REQ_ALLOC, 64'h8000_0000, 64'h8000_0000, 8'h80);
        push_cmd(REQ_FREE, 64'h1_0000, 64'h0, 8'h00);
    endtask

    // Mostly well-formed allocate and free traffic so the table keeps churning;
    // frees mostly name a base handed out earlier, and a small set of low bases
    // makes duplicate entries and first-match order matter.
    task automatic queue_random(int n);
        int unsigned roll;
        int unsigned pick;
        logic [31:0] lo;
        logic [63:0] size;
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(99);
            lo   = ($urandom_range(3) == 0) ? {17'd0, 3'($urandom_range(7)), 12'd0}
                                            : {$urandom() & PAGE_HIGH_MASK};
            pick = $urandom_range(99);
            if (pick < 60) begin
                size = 64'h1 << $urandom_range(63, 12);
            end else if (pick < 75) begin
                size = 64'h0;
            end else begin
                size = {$urandom(), $urandom()} & ~64'hfff;
            end
            if (roll < 45) begin
                push_cmd(REQ_ALLOC, {$urandom(), lo}, size, 8'($urandom_range(255)));
                base_pool.push_back(lo);
                if (base_pool.size() > 16) begin
                    void'(base_pool.pop_front());
                end
            end else if (roll < 85) begin
                if (base_pool.size() != 0) begin
                    pick = $urandom_range(base_pool.size() - 1);
                    lo = base_pool[pick];
                    base_pool.delete(pick);
                end
                push_cmd(REQ_FREE, {$urandom(), lo}, {$urandom(), $urandom()},
                         8'($urandom_range(255)));
            end else if (roll < 92) begin
                // Aligned base with a size that may carry low bits.
                push_cmd(1'($urandom_range(1)), {$urandom(), lo},
                         {$urandom(), $urandom()}, 8'($urandom_range(255)));
            end else begin
                push_cmd(1'($urandom_range(1)), {$urandom(), $urandom()},
                         {$urandom(), $urandom()}, 8'($urandom_range(255)));
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values first, with the directed sequence and no sender gaps.
        start_phase(1'b1, 4'd8, 0);
        queue_directed();
        queue_random(400);

        start_phase(1'b1, 4'd3, 67);
        queue_random(350);

        // Feature absent: every request is refused whatever its shape.
        start_phase(1'b0, 4'd8, 0);
        queue_random(100);

        // Largest active count; the scan still stops at the end of the table.
        start_phase(1'b1, 4'd15, 26);
        queue_random(450);

        // No active slots: allocates find no space and frees find nothing.
        start_phase(1'b1, 4'd0, 67);
        queue_random(100);

        start_phase(1'b1, 4'd1, 0);
        queue_random(200);

        start_phase(1'b1, 4'd8, 26);
        queue_random(400);

        // Let every request go in, then give the last beats time to come out.
        do @(negedge i_clk);
        while (cmd_q.size() != 0 || start || busy);
        for (int n = 0; n < 4 * TAIL_CYCLES && slot_result_q.size() != 0; n++) begin
            @(negedge i_clk);
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (slot_result_q.size() != 0) begin
            report_mismatch("results never delivered", 64'(slot_result_q.size()), 64'd0);
        end

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
